// ===== rtl/assert_macros.svh =====
// assertion helpers used by the allocator top level
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ffea_pkg.sv =====
// types and codes of the first-fit extent allocator
// no dependencies
package ffea_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_ZEROFREE = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] request_size;
    logic [31:0] request_offset;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [31:0] free_total;
  } rsp_t;

  localparam logic [31:0] TotalSpaceReset = 32'd65536;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // exact end-of-extent compare, no wrap
  function automatic logic touches(input logic [31:0] s, input logic [31:0] l,
                                   input logic [31:0] nxt);
    return ({1'b0, s} + {1'b0, l}) == {1'b0, nxt};
  endfunction

endpackage

// ===== rtl/ffea_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ffea_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/first_fit_extent_allocator_unit.sv =====
// first-fit extent allocator: top level, command sequencer and config register
// depends on ffea_pkg, ffea_ram and assert_macros.svh
//
// usage: one request beat on in_i (command, size, offset) gives one response
// beat on out_o. allocate takes space from the first free extent big enough,
// free inserts or grows an extent and merges neighbors, clear restores one
// extent of total_space, query reports the free total (every response has it).
// each request other than clear streams the extent table through the ram:
// a read state and an update state per stored extent, and a free that adds
// an extent apart from the next one reads that next extent again. the pace is
// set by the single read port of the extent ram. one request is in work at a
// time; a response waits in the output register while the receiver stalls,
// and the next request is taken once the previous one has been processed.
// after reset the S_INIT state writes the single extent (0, 65536) into the
// ram; in_ready_o is low in that state. total_space is written over the
// apb port at any address and only takes effect at the next clear.
`include "assert_macros.svh"

module first_fit_extent_allocator_unit #(
  parameter int MAX_EXTENTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ffea_pkg::req_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ffea_pkg::rsp_t out_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ffea_pkg::*;

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int SW = 32 + $clog2(MAX_EXTENTS);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_PR   = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;
  localparam logic [2:0] S_FL   = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;
  localparam logic [2:0] S_RSP  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [31:0]   total_q;
  logic [CW-1:0] count_q, count_d, j_q, j_d, w_q, w_d;
  logic          p_vld_q, p_vld_d, done_q, done_d, mn_q, mn_d;
  logic [31:0]   p_start_q, p_start_d, p_len_q, p_len_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [31:0]   size_q, size_d, off_q, off_d, grant_q, grant_d;
  status_e       status_q, status_d;
  logic [SW-1:0] sum_q, sum_d;
  rsp_t          out_q, out_d;
  logic          out_vld_q, out_vld_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic [31:0]   e_start, e_len;
  logic          do_push, adv, consumed, full;
  logic [31:0]   push_start, push_len, n_len;

  assign pready = 1'b1;
  assign prdata = total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalSpaceReset;
    end else if (psel && penable && pwrite && paddr[1] == 1'b0) begin
      total_q <= pwdata;
    end else if (psel && penable && pwrite) begin
      total_q <= pwdata;
    end
  end

  ffea_ram #(.Width(64), .Depth(MAX_EXTENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign e_start = rdata[63:32];
  assign e_len   = rdata[31:0];
  assign full    = (count_q == CW'(MAX_EXTENTS));
  assign raddr   = j_q[AW-1:0];
  assign re      = (state_q == S_RD);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    j_d       = j_q;
    w_d       = w_q;
    p_vld_d   = p_vld_q;
    p_start_d = p_start_q;
    p_len_d   = p_len_q;
    done_d    = done_q;
    mn_d      = mn_q;
    cmd_d     = cmd_q;
    size_d    = size_q;
    off_d     = off_q;
    grant_d   = grant_q;
    status_d  = status_q;
    sum_d     = sum_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    we        = 1'b0;
    waddr     = w_q[AW-1:0];
    wdata     = {p_start_q, p_len_q};
    do_push   = 1'b0;
    push_start = e_start;
    push_len   = e_len;
    adv       = 1'b1;
    consumed  = 1'b0;
    n_len     = size_q;

    unique case (state_q)
      S_INIT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = {32'd0, TotalSpaceReset};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_i.command;
          size_d  = in_i.request_size;
          off_d   = in_i.request_offset;
          j_d     = '0;
          w_d     = '0;
          p_vld_d = 1'b0;
          mn_d    = 1'b0;
          sum_d   = '0;
          grant_d = '0;
          done_d  = 1'b1;
          status_d = ST_OK;
          if (in_i.command == CMD_ALLOC) begin
            done_d   = 1'b0;
            status_d = ST_NOSPACE;
          end else if (in_i.command == CMD_FREE) begin
            if (in_i.request_size == 32'd0) begin
              status_d = ST_ZEROFREE;
            end else begin
              done_d = 1'b0;
            end
          end
          if (in_i.command == CMD_CLEAR) begin
            state_d = S_CLR;
          end else if (count_q == '0) begin
            state_d = S_END;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_PR;
      end
      S_PR: begin
        mn_d = 1'b0;
        if (!done_q) begin
          if (cmd_q == CMD_ALLOC) begin
            if (e_len == size_q) begin
              grant_d  = e_start;
              status_d = ST_OK;
              done_d   = 1'b1;
            end else if (e_len > size_q) begin
              do_push    = 1'b1;
              push_start = e_start + size_q;
              push_len   = e_len - size_q;
              grant_d    = e_start;
              status_d   = ST_OK;
              done_d     = 1'b1;
            end else begin
              do_push = 1'b1;
            end
          end else begin
            if (e_start == off_q) begin
              do_push  = 1'b1;
              push_len = sat_add(e_len, size_q);
              mn_d     = 1'b1;
              done_d   = 1'b1;
            end else if (e_start > off_q) begin
              done_d = 1'b1;
              if (full) begin
                status_d = ST_FULL;
                do_push  = 1'b1;
              end else begin
                // new extent absorbs the one after it, then the one before absorbs it
                consumed = touches(off_q, size_q, e_start);
                n_len    = consumed ? sat_add(size_q, e_len) : size_q;
                if (p_vld_q && touches(p_start_q, p_len_q, off_q)) begin
                  p_len_d = sat_add(p_len_q, n_len);
                end else begin
                  do_push    = 1'b1;
                  push_start = off_q;
                  push_len   = n_len;
                end
                // current extent still to be written: read it again
                adv = consumed;
              end
            end else begin
              do_push = 1'b1;
            end
          end
        end else if (mn_q && p_vld_q && touches(p_start_q, p_len_q, e_start)) begin
          p_len_d = sat_add(p_len_q, e_len);
        end else begin
          do_push = 1'b1;
        end
        if (adv) begin
          j_d = j_q + CW'(1);
        end
        state_d = ((adv ? j_q + CW'(1) : j_q) < count_q) ? S_RD : S_END;
      end
      S_END: begin
        if (cmd_q == CMD_FREE && !done_q) begin
          if (full) begin
            status_d = ST_FULL;
          end else if (p_vld_q && touches(p_start_q, p_len_q, off_q)) begin
            p_len_d = sat_add(p_len_q, size_q);
          end else begin
            do_push    = 1'b1;
            push_start = off_q;
            push_len   = size_q;
          end
        end
        state_d = S_FL;
      end
      S_FL: begin
        if (p_vld_q) begin
          we      = 1'b1;
          sum_d   = sum_q + SW'(p_len_q);
          count_d = w_q + CW'(1);
        end else begin
          count_d = w_q;
        end
        state_d = S_RSP;
      end
      S_CLR: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = {32'd0, total_q};
        count_d = CW'(1);
        sum_d   = SW'(total_q);
        state_d = S_RSP;
      end
      S_RSP: begin
        if (!out_vld_q || out_ready_i) begin
          out_d.ok             = (status_q == ST_OK);
          out_d.status         = status_q;
          out_d.granted_offset = (status_q == ST_OK) ? grant_q : 32'd0;
          out_d.free_total     = (sum_q[SW-1:32] != '0) ? 32'hFFFF_FFFF : sum_q[31:0];
          out_vld_d            = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // pending extent goes to the ram, new one takes its place
    if (do_push) begin
      if (p_vld_q) begin
        we    = 1'b1;
        waddr = w_q[AW-1:0];
        wdata = {p_start_q, p_len_q};
        w_d   = w_q + CW'(1);
        sum_d = sum_q + SW'(p_len_q);
      end
      p_vld_d   = 1'b1;
      p_start_d = push_start;
      p_len_d   = push_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      count_q   <= CW'(1);
      j_q       <= '0;
      w_q       <= '0;
      p_vld_q   <= 1'b0;
      done_q    <= 1'b0;
      mn_q      <= 1'b0;
      out_vld_q <= 1'b0;
      status_q  <= ST_OK;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      j_q       <= j_d;
      w_q       <= w_d;
      p_vld_q   <= p_vld_d;
      done_q    <= done_d;
      mn_q      <= mn_d;
      out_vld_q <= out_vld_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_start_q <= p_start_d;
    p_len_q   <= p_len_d;
    cmd_q     <= cmd_d;
    size_q    <= size_d;
    off_q     <= off_d;
    grant_q   <= grant_d;
    sum_q     <= sum_d;
    out_q     <= out_d;
  end

  `ASSERT_ALWAYS(a_count_bound, count_q <= CW'(MAX_EXTENTS))
  `ASSERT_IMPLY(a_write_behind_read, we && (state_q == S_PR || state_q == S_END),
                {1'b0, waddr} <= {1'b0, j_q[AW-1:0]} || j_q == CW'(MAX_EXTENTS))
  `ASSERT_IMPLY(a_ok_matches_status, out_valid_o, out_o.ok == (out_o.status == ST_OK))
  `ASSERT_IMPLY(a_no_read_when_idle, state_q == S_IDLE, !re && !we)
endmodule
